[hw/rtl/modbus_rtu_vfd_master_framer_defines.svh]
// Assertion macros shared by the framer checker.
// No dependencies; include by bare file name.
`ifndef MODBUS_RTU_VFD_MASTER_FRAMER_DEFINES_SVH
`define MODBUS_RTU_VFD_MASTER_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRVF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, disabled during reset.
`define MRVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

[hw/rtl/mrvf_pkg.sv]
// Types, codes and constants of the Modbus RTU drive framer.
// No dependencies.
`default_nettype none
package mrvf_pkg;

  typedef enum logic [1:0] {
    FN_SEND      = 2'd0,
    FN_RX_BYTE   = 2'd1,
    FN_FRAME_END = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    CMD_RD_STATUS  = 3'd0,
    CMD_RD_MAX_RPM = 3'd1,
    CMD_RD_CUR_RPM = 3'd2,
    CMD_SET_DIR    = 3'd3,
    CMD_SET_SPEED  = 3'd4
  } command_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CRC      = 3'd2,
    ST_FUNC     = 3'd3,
    ST_ADDR     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CRC,
    S_EMIT,
    S_RD_MEM,
    S_RD_LAST,
    S_REPORT
  } ctrl_state_e;

  localparam logic       REG_DEVICE_ADDR = 1'b0;
  localparam logic       REG_MAX_RPM     = 1'b1;

  localparam logic       KIND_TX     = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;

  localparam logic [1:0] DIR_IDLE    = 2'd0;
  localparam logic [1:0] DIR_FWD     = 2'd1;
  localparam logic [1:0] DIR_REV     = 2'd2;
  localparam logic [1:0] DIR_UNKNOWN = 2'd3;

  localparam logic [7:0] FC_READ  = 8'h03;
  localparam logic [7:0] FC_WRITE = 8'h06;

  localparam logic [7:0] REQ_DIR_REV  = 8'h02;
  localparam logic [7:0] REQ_DIR_STOP = 8'h06;
  localparam logic [7:0] REQ_DIR_FWD  = 8'h01;

  localparam logic [15:0] SPEED_FULL = 16'd10000;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam int unsigned MIN_REPLY  = 6;

  typedef struct packed {
    logic ld_send;
    logic div_step;
    logic crc_step;
    logic emit;
    logic rx_wr;
    logic ld_eof;
    logic rd_step;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_last;
    logic crc_last;
    logic emit_last;
    logic rd_last;
    logic rx_bad;
  } dp_stat_t;

  // One byte of the reflected CRC-16 (poly 0xA001).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/modbus_rtu_vfd_master_framer.sv]
// Top level of the Modbus RTU drive framer: stream ports, config port.
// Depends on mrvf_pkg, mrvf_ctrl, mrvf_dp (and mrvf_ram below it).
//
// One item at a time. A read or direction request is accepted, run through
// the CRC unit (one byte per cycle over the 6 frame bytes) and then sent as 8
// transfers; set speed first runs the bit-serial divider that scales the
// requested rpm to 0..10000 of max rpm. A received byte is one write into the
// receive RAM, or sets the overflow flag when the RAM is full. A frame end
// reads the reply back (one RAM read per cycle through the CRC unit), or skips
// the read when the reply is short or overflowed, then makes one report
// transfer. The output register holds a result while the sink stalls; the
// block takes new input only between items.
`default_nettype none
module modbus_rtu_vfd_master_framer #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: index 0 device address, 1 max rpm
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: command[2:0], turn_direction[4:3], req_rpm[20:5], rx_byte[28:21]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: tx_byte[7:0], status[10:8], reply_value[26:11], drive_direction[28:27]
  output logic [31:0]      m_axis_tdata,
  // tuser: kind[0]
  output logic             m_axis_tuser,
  // tlast: last_byte
  output logic             m_axis_tlast
);
  import mrvf_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [7:0]  tx;
  logic [2:0]  st;
  logic [15:0] val;
  logic [1:0]  dir;

  mrvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_cmd_i   (s_axis_tdata[2:0]),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  mrvf_dp #(.RX_DEPTH(RX_DEPTH)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tdata[2:0]),
    .in_dir_i     (s_axis_tdata[4:3]),
    .in_rpm_i     (s_axis_tdata[20:5]),
    .in_rx_i      (s_axis_tdata[28:21]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_tx_o     (tx),
    .out_status_o (st),
    .out_value_o  (val),
    .out_dir_o    (dir)
  );

  // Pack the result fields, lowest first, zero pad to 32 bits.
  assign m_axis_tdata = {3'b000, dir, val, st, tx};
endmodule
`default_nettype wire

[hw/rtl/mrvf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mrvf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/mrvf_ctrl.sv]
// Sequencer of the framer: decodes accepted items and steps the datapath.
// Depends on mrvf_pkg.
`default_nettype none
module mrvf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_func_i,
  input  wire logic [2:0]        in_cmd_i,
  input  wire mrvf_pkg::dp_stat_t stat_i,
  output logic                   in_ready_o,
  output mrvf_pkg::dp_cmd_t      cmd_o
);
  import mrvf_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_e'(in_func_i))
            FN_SEND: begin
              if (in_cmd_i <= CMD_SET_SPEED) begin
                cmd_o.ld_send = 1'b1;
                state_d = (in_cmd_i == CMD_SET_SPEED) ? S_DIV : S_CRC;
              end
            end
            FN_RX_BYTE: cmd_o.rx_wr = 1'b1;
            FN_FRAME_END: begin
              cmd_o.ld_eof = 1'b1;
              state_d = stat_i.rx_bad ? S_REPORT : S_RD_MEM;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_CRC;
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (stat_i.crc_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) state_d = S_IDLE;
        end
      end
      S_RD_MEM: begin
        cmd_o.rd_step = 1'b1;
        if (stat_i.rd_last) state_d = S_RD_LAST;
      end
      S_RD_LAST: state_d = S_REPORT;
      S_REPORT: begin
        if (stat_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/mrvf_dp.sv]
// Datapath of the framer: registers, speed divider, CRC unit, receive store
// and output register. Depends on mrvf_pkg and mrvf_ram.
`default_nettype none
module mrvf_dp #(
  parameter int unsigned RX_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic [2:0]        in_cmd_i,
  input  wire logic [1:0]        in_dir_i,
  input  wire logic [15:0]       in_rpm_i,
  input  wire logic [7:0]        in_rx_i,
  input  wire mrvf_pkg::dp_cmd_t cmd_i,
  output mrvf_pkg::dp_stat_t     stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_kind_o,
  output logic                   out_last_o,
  output logic [7:0]             out_tx_o,
  output logic [2:0]             out_status_o,
  output logic [15:0]            out_value_o,
  output logic [1:0]             out_dir_o
);
  import mrvf_pkg::*;

  localparam int unsigned AW   = $clog2(RX_DEPTH);
  localparam int unsigned CW   = $clog2(RX_DEPTH + 1);
  localparam int unsigned CNTW = (AW > 4) ? AW : 4;

  logic [7:0]      dev_addr_q;
  logic [15:0]     max_rpm_q;
  logic [CW-1:0]   rx_count_q;
  logic            rx_ovf_q;
  logic [7:0]      sent_fn_q;
  logic [CNTW-1:0] cnt_q;
  logic [7:0]      fb_q [6];
  logic [15:0]     crc_q;
  logic [29:0]     prod_q;
  logic            sat_q;
  logic [15:0]     rem_q;
  logic [13:0]     quo_q;
  logic            pend_q;
  logic [AW-1:0]   pend_idx_q;
  logic [7:0]      b0_q, b1_q, b4_q, b5_q, clo_q, chi_q;
  logic [7:0]      rdata;

  // Divider step: restoring long division, one quotient bit a cycle.
  logic [15:0] rem_in;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_d;
  logic [13:0] quo_d;
  logic [13:0] prod_lo;
  logic [15:0] speed;

  assign prod_lo = prod_q[13:0];
  assign rem_in  = (cnt_q[3:0] == 4'd0) ? prod_q[29:14] : rem_q;
  assign trial   = {rem_in, prod_lo[4'd13 - cnt_q[3:0]]};
  assign ge      = trial >= {1'b0, max_rpm_q};
  assign rem_d   = ge ? 16'(trial - {1'b0, max_rpm_q}) : trial[15:0];
  assign quo_d   = {quo_q[12:0], ge};
  assign speed   = sat_q ? SPEED_FULL : {2'b00, quo_d};

  logic [7:0] byte_sel;
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    byte_sel = fb_q[0];
      3'd1:    byte_sel = fb_q[1];
      3'd2:    byte_sel = fb_q[2];
      3'd3:    byte_sel = fb_q[3];
      3'd4:    byte_sel = fb_q[4];
      3'd5:    byte_sel = fb_q[5];
      3'd6:    byte_sel = crc_q[7:0];
      default: byte_sel = crc_q[15:8];
    endcase
  end

  logic [7:0] dir_byte;
  assign dir_byte = in_dir_i[1] ? REQ_DIR_REV :
                    (in_dir_i == 2'b00) ? REQ_DIR_STOP : REQ_DIR_FWD;

  logic [CW-1:0] n_crc;
  logic [CW-1:0] pend_w;
  logic          rx_full;
  assign n_crc   = rx_count_q - CW'(2);
  assign pend_w  = CW'(pend_idx_q);
  assign rx_full = rx_count_q >= CW'(RX_DEPTH);

  mrvf_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rx_wr && !rx_full),
    .waddr_i (rx_count_q[AW-1:0]),
    .wdata_i (in_rx_i),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Report fields.
  status_e     rpt_st;
  logic [15:0] rpt_val;
  logic [1:0]  rpt_dir;
  always_comb begin
    if (rx_ovf_q)                                rpt_st = ST_OVERFLOW;
    else if (rx_count_q < CW'(MIN_REPLY))        rpt_st = ST_SHORT;
    else if ({chi_q, clo_q} != crc_q)            rpt_st = ST_CRC;
    else if (b1_q != sent_fn_q)                  rpt_st = ST_FUNC;
    else if (b0_q != dev_addr_q)                 rpt_st = ST_ADDR;
    else                                         rpt_st = ST_OK;
    rpt_val = (rpt_st == ST_OK) ? {b4_q, b5_q} : 16'd0;
    rpt_dir = DIR_UNKNOWN;
    if (rpt_st == ST_OK) begin
      case (rpt_val)
        16'd1:   rpt_dir = DIR_FWD;
        16'd2:   rpt_dir = DIR_REV;
        16'd3:   rpt_dir = DIR_IDLE;
        default: rpt_dir = DIR_UNKNOWN;
      endcase
    end
  end

  assign stat_o.out_free  = !out_valid_o || out_ready_i;
  assign stat_o.div_last  = cnt_q[3:0] == 4'd13;
  assign stat_o.crc_last  = cnt_q[2:0] == 3'd5;
  assign stat_o.emit_last = cnt_q[2:0] == 3'd7;
  assign stat_o.rd_last   = CW'(cnt_q[AW-1:0]) == (rx_count_q - CW'(1));
  assign stat_o.rx_bad    = rx_ovf_q || (rx_count_q < CW'(MIN_REPLY));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 8'd1;
      max_rpm_q   <= 16'd24000;
      rx_count_q  <= '0;
      rx_ovf_q    <= 1'b0;
      sent_fn_q   <= 8'd0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEVICE_ADDR: dev_addr_q <= cfg_data_i[7:0];
          default:         max_rpm_q  <= cfg_data_i;
        endcase
      end
      pend_q <= cmd_i.rd_step;
      // Load the output register on a new result, else drop it after its transfer.
      if (cmd_i.emit || cmd_i.report) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.ld_send) begin
        cnt_q      <= '0;
        rx_count_q <= '0;
        rx_ovf_q   <= 1'b0;
        sent_fn_q  <= (in_cmd_i >= CMD_SET_DIR) ? FC_WRITE : FC_READ;
      end
      if (cmd_i.div_step) cnt_q <= stat_o.div_last ? '0 : cnt_q + CNTW'(1);
      if (cmd_i.crc_step) cnt_q <= stat_o.crc_last ? '0 : cnt_q + CNTW'(1);
      if (cmd_i.emit) begin
        cnt_q <= stat_o.emit_last ? '0 : cnt_q + CNTW'(1);
      end
      if (cmd_i.rx_wr) begin
        if (rx_full) rx_ovf_q <= 1'b1;
        else         rx_count_q <= rx_count_q + CW'(1);
      end
      if (cmd_i.ld_eof)  cnt_q <= '0;
      if (cmd_i.rd_step) cnt_q <= cnt_q + CNTW'(1);
      if (cmd_i.report) begin
        rx_count_q  <= '0;
        rx_ovf_q    <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_send) begin
      prod_q <= 30'(in_rpm_i) * 30'(SPEED_FULL);
      sat_q  <= in_rpm_i >= max_rpm_q;
      crc_q  <= CRC_INIT;
      fb_q[0] <= dev_addr_q;
      fb_q[4] <= 8'h00;
      case (command_e'(in_cmd_i))
        CMD_RD_STATUS:  begin
          fb_q[1] <= FC_READ; fb_q[2] <= 8'h30; fb_q[3] <= 8'h00; fb_q[5] <= 8'h01;
        end
        CMD_RD_MAX_RPM: begin
          fb_q[1] <= FC_READ; fb_q[2] <= 8'hB0; fb_q[3] <= 8'h05; fb_q[5] <= 8'h02;
        end
        CMD_RD_CUR_RPM: begin
          fb_q[1] <= FC_READ; fb_q[2] <= 8'h70; fb_q[3] <= 8'h0C; fb_q[5] <= 8'h02;
        end
        CMD_SET_DIR:    begin
          fb_q[1] <= FC_WRITE; fb_q[2] <= 8'h20; fb_q[3] <= 8'h00; fb_q[5] <= dir_byte;
        end
        default:        begin
          fb_q[1] <= FC_WRITE; fb_q[2] <= 8'h10; fb_q[3] <= 8'h00; fb_q[5] <= 8'h00;
        end
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (stat_o.div_last) begin
        fb_q[4] <= speed[15:8];
        fb_q[5] <= speed[7:0];
      end
    end
    if (cmd_i.crc_step) crc_q <= crc_byte(crc_q, byte_sel);
    if (cmd_i.ld_eof)   crc_q <= CRC_INIT;
    if (pend_q) begin
      if (pend_w < n_crc) crc_q <= crc_byte(crc_q, rdata);
      if (pend_idx_q == AW'(0)) b0_q <= rdata;
      if (pend_idx_q == AW'(1)) b1_q <= rdata;
      if (pend_idx_q == AW'(4)) b4_q <= rdata;
      if (pend_idx_q == AW'(5)) b5_q <= rdata;
      if (pend_w == n_crc) clo_q <= rdata;
      if (pend_w == n_crc + CW'(1)) chi_q <= rdata;
    end
    pend_idx_q <= cnt_q[AW-1:0];
    if (cmd_i.emit) begin
      out_kind_o   <= KIND_TX;
      out_last_o   <= stat_o.emit_last;
      out_tx_o     <= byte_sel;
      out_status_o <= ST_OK;
      out_value_o  <= 16'd0;
      out_dir_o    <= DIR_IDLE;
    end
    if (cmd_i.report) begin
      out_kind_o   <= KIND_REPORT;
      out_last_o   <= 1'b0;
      out_tx_o     <= 8'd0;
      out_status_o <= rpt_st;
      out_value_o  <= rpt_val;
      out_dir_o    <= rpt_dir;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mrvf_checker.sv]
// Port-level checks of the framer, bound to the top level.
// Depends on modbus_rtu_vfd_master_framer_defines.svh.
`default_nettype none
`include "modbus_rtu_vfd_master_framer_defines.svh"
module mrvf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  `MRVF_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MRVF_ASSERT_IMPLY(a_tx_clean, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:8] == 24'd0)
  `MRVF_ASSERT_IMPLY(a_rpt_nolast, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, !m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
  `MRVF_ASSERT_IMPLY(a_rpt_err, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != 3'd0, m_axis_tdata[28:11] == 18'h30000)
endmodule

bind modbus_rtu_vfd_master_framer mrvf_checker u_mrvf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
